// ===== rtl/sct_pkg.sv =====
// Shared types and constants for the sorted sparse cell table.
package sct_pkg;

  localparam int ROW_W      = 16;
  localparam int COL_W      = 16;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 7;
  localparam int OCC_W      = 7;
  localparam int STATUS_W   = 2;

  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_READ_WAIT,
    S_RESP
  } state_e;

endpackage

// ===== rtl/sorted_sparse_cell_table.sv =====
// Sorted sparse cell table: top level with request sequencer and result register.
//
// Keeps up to CAPACITY nonzero (row, column, value) cells in one table memory, in
// ascending row-then-column order. A request is taken only while the sequencer is
// idle and always yields one result. A read fetches the indexed entry from the table
// memory. A write first walks the table from position 0, reading and comparing one
// entry at a time, until it finds the key or passes it, then either updates in place,
// or moves every later entry one place up (insert) or down (delete), reading each
// and writing it back one place over. This entry-by-entry pace is set by the single
// read port of the table memory, whose data arrives in the cycle after the address. A
// finished result waits in an output register, so the next request can be taken while
// it is still stalled. A new cell offered to a full table is dropped with status 2.
module sorted_sparse_cell_table #(
  parameter int CAPACITY   = sct_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [sct_pkg::ROW_W-1:0]      cell_row_i,
  input  logic [sct_pkg::COL_W-1:0]      cell_col_i,
  input  logic signed [sct_pkg::VAL_W-1:0] cell_value_i,
  input  logic [sct_pkg::IDX_W-1:0]      entry_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sct_pkg::STATUS_W-1:0]   status_o,
  output logic [sct_pkg::ROW_W-1:0]      entry_row_o,
  output logic [sct_pkg::COL_W-1:0]      entry_col_o,
  output logic signed [sct_pkg::VAL_W-1:0] entry_value_o,
  output logic [sct_pkg::OCC_W-1:0]      occupied_count_o
);

  import sct_pkg::*;

  // stored coordinate width: ports are 16 bits, so anything wider is zero
  localparam int CW     = (COORD_BITS < ROW_W) ? COORD_BITS : ROW_W;
  localparam int KEY_W  = 2 * CW;
  localparam int WORD_W = KEY_W + VAL_W;
  localparam int AW     = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = CNT_W + IDX_W;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   val_q, val_d;
  status_e            res_status_q, res_status_d;
  logic [WORD_W-1:0]  res_word_q, res_word_d;

  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [WORD_W-1:0]  out_word_q;
  logic               out_load;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic               in_xfer;
  logic               out_free;
  logic [CNT_W-1:0]   ptr_inc, ptr_dec;
  logic [CMP_W-1:0]   idx_ext, count_ext;
  logic [KEY_W-1:0]   rd_key;

  sct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ptr_inc    = ptr_q + CNT_W'(1);
  assign ptr_dec    = ptr_q - CNT_W'(1);
  assign idx_ext    = CMP_W'(entry_index_i);
  assign count_ext  = CMP_W'(count_q);
  assign rd_key     = ram_rdata[WORD_W-1:VAL_W];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    key_d        = key_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_word_d   = res_word_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = ptr_q[AW-1:0];
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          key_d        = {cell_row_i[CW-1:0], cell_col_i[CW-1:0]};
          val_d        = cell_value_i;
          res_status_d = ST_OK;
          res_word_d   = '0;
          ptr_d        = '0;
          if (req_type_i == REQ_READ) begin
            if (idx_ext < count_ext) begin
              ram_raddr = idx_ext[AW-1:0];
              state_d   = S_READ_WAIT;
            end else begin
              res_status_d = ST_BAD_INDEX;
              state_d      = S_RESP;
            end
          end else if (count_q == '0) begin
            pos_d   = '0;
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (rd_key < key_q) begin
          if (ptr_inc == count_q) begin
            pos_d   = count_q;
            state_d = S_DECIDE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_SCAN_RD;
          end
        end else begin
          pos_d   = ptr_q;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // rd_key still holds the entry at pos when the scan stopped inside the table
        if (pos_q != count_q && rd_key == key_q) begin
          if (val_q != '0) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[AW-1:0];
            ram_wdata = {key_q, val_q};
            state_d   = S_RESP;
          end else begin
            ptr_d   = pos_q;
            state_d = S_DEL_RD;
          end
        end else if (val_q != '0) begin
          if (count_q == CNT_W'(CAPACITY)) begin
            res_status_d = ST_FULL;
            state_d      = S_RESP;
          end else begin
            ptr_d   = count_q;
            state_d = S_INS_RD;
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_DEL_RD: begin
        if (ptr_inc < count_q) begin
          ram_raddr = ptr_inc[AW-1:0];
          state_d   = S_DEL_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_DEL_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DEL_RD;
      end

      S_INS_RD: begin
        if (ptr_q > pos_q) begin
          ram_raddr = ptr_dec[AW-1:0];
          state_d   = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = {key_q, val_q};
          count_d   = count_q + CNT_W'(1);
          state_d   = S_RESP;
        end
      end

      S_INS_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_INS_RD;
      end

      S_READ_WAIT: begin
        res_word_d = ram_rdata;
        state_d    = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    key_q        <= key_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_word_q   <= res_word_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_word_q   <= res_word_q;
    end
  end

  logic [CMP_W-1:0] occ_ext;
  logic [CNT_W-1:0] occ_q;

  // count is final by the time the result is loaded
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      occ_q <= count_q;
    end
  end

  assign occ_ext          = CMP_W'(occ_q);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_row_o      = ROW_W'(out_word_q[WORD_W-1:WORD_W-CW]);
  assign entry_col_o      = COL_W'(out_word_q[VAL_W+CW-1:VAL_W]);
  assign entry_value_o    = out_word_q[VAL_W-1:0];
  assign occupied_count_o = occ_ext[OCC_W-1:0];

endmodule

// ===== rtl/sct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_sorted_sparse_cell_table.sv =====
// Self-checking testbench for the sorted sparse cell table: directed and random requests.
module tb_sorted_sparse_cell_table;
  import sct_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int LIMIT     = 2000000;
  localparam int RAND_REQS = 1030;
  localparam int TAIL      = 120;
  localparam int HOLD_AT   = 200;
  localparam int HOLD_LEN  = 1500;
  localparam int DRAIN_GAP = 300;

  typedef struct {
    req_e                     kind;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         index;
  } cell_req_t;

  typedef struct {
    status_e                  status;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [OCC_W-1:0]         count;
  } cell_result_t;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_WIDE} mix_e;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [ROW_W-1:0] cell_row = '0;
  logic [COL_W-1:0] cell_col = '0;
  logic signed [VAL_W-1:0] cell_value = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ROW_W-1:0] entry_row;
  logic [COL_W-1:0] entry_col;
  logic signed [VAL_W-1:0] entry_value;
  logic [OCC_W-1:0] occupied_count;

  sorted_sparse_cell_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .cell_row_i       (cell_row),
    .cell_col_i       (cell_col),
    .cell_value_i     (cell_value),
    .entry_index_i    (entry_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .entry_row_o      (entry_row),
    .entry_col_o      (entry_col),
    .entry_value_o    (entry_value),
    .occupied_count_o (occupied_count)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the cell table
  logic [ROW_W-1:0]        tbl_row [CAP];
  logic [COL_W-1:0]        tbl_col [CAP];
  logic signed [VAL_W-1:0] tbl_val [CAP];
  int                      tbl_count = 0;

  cell_req_t    pending_reqs [$];
  cell_result_t expected_results [$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  bit           in_taken = 1'b0;
  bit           quiet_tail = 1'b0;
  int           in_gap = 0;
  int           out_burst = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  cell_req_t    next_req;
  cell_req_t    seen_req;
  cell_result_t want;

  function automatic cell_result_t table_apply(cell_req_t rq);
    cell_result_t res;
    int pos;
    int i;
    bit hit;
    res.status = ST_OK;
    res.row = '0;
    res.col = '0;
    res.value = '0;
    if (rq.kind == REQ_WRITE) begin
      pos = 0;
      while (pos < tbl_count && {tbl_row[pos], tbl_col[pos]} < {rq.row, rq.col}) pos++;
      hit = pos < tbl_count && {tbl_row[pos], tbl_col[pos]} == {rq.row, rq.col};
      if (hit) begin
        if (rq.value != 0) begin
          tbl_val[pos] = rq.value;
        end else begin
          for (i = pos; i < tbl_count - 1; i++) begin
            tbl_row[i] = tbl_row[i + 1];
            tbl_col[i] = tbl_col[i + 1];
            tbl_val[i] = tbl_val[i + 1];
          end
          tbl_count--;
        end
      end else if (rq.value != 0) begin
        if (tbl_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = tbl_count; i > pos; i--) begin
            tbl_row[i] = tbl_row[i - 1];
            tbl_col[i] = tbl_col[i - 1];
            tbl_val[i] = tbl_val[i - 1];
          end
          tbl_row[pos] = rq.row;
          tbl_col[pos] = rq.col;
          tbl_val[pos] = rq.value;
          tbl_count++;
        end
      end
    end else begin
      if (rq.index < tbl_count) begin
        res.row = tbl_row[rq.index];
        res.col = tbl_col[rq.index];
        res.value = tbl_val[rq.index];
      end else begin
        res.status = ST_BAD_INDEX;
      end
    end
    res.count = tbl_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic add_write(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                           input logic signed [VAL_W-1:0] v);
    cell_req_t rq;
    rq.kind = REQ_WRITE;
    rq.row = r;
    rq.col = c;
    rq.value = v;
    rq.index = IDX_W'($urandom);
    pending_reqs.push_back(rq);
  endtask

  task automatic add_read(input logic [IDX_W-1:0] idx);
    cell_req_t rq;
    rq.kind = REQ_READ;
    rq.row = ROW_W'($urandom);
    rq.col = COL_W'($urandom);
    rq.value = VAL_W'($urandom);
    rq.index = idx;
    pending_reqs.push_back(rq);
  endtask

  function automatic logic signed [VAL_W-1:0] nonzero_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = -32'sd1;
      3: v = 32'sd1;
      default: v = $urandom;
    endcase
    if (v == 0) v = 32'sd1;
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 127));
    return IDX_W'($urandom_range(0, CAP + 6));
  endfunction

  // Sender: next transfer offered at the falling edge once the last one went through
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        req_type <= next_req.kind;
        cell_row <= next_req.row;
        cell_col <= next_req.col;
        cell_value <= next_req.value;
        entry_index <= next_req.index;
        in_valid <= 1'b1;
        if (pending_reqs.size() < TAIL) quiet_tail = 1'b1;
        if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls: short random bursts, plus one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (out_burst > 0) begin
      out_stall <= 1'b1;
      out_burst--;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      out_burst = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid && !in_stall;
    if (in_taken) begin
      seen_req.kind = req_e'(req_type);
      seen_req.row = cell_row;
      seen_req.col = cell_col;
      seen_req.value = cell_value;
      seen_req.index = entry_index;
      expected_results.push_back(table_apply(seen_req));
    end
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (entry_row !== want.row)
          flag_mismatch($sformatf("entry_row got %h want %h", entry_row, want.row));
        if (entry_col !== want.col)
          flag_mismatch($sformatf("entry_col got %h want %h", entry_col, want.col));
        if (entry_value !== want.value)
          flag_mismatch($sformatf("entry_value got %h want %h", entry_value, want.value));
        if (occupied_count !== want.count)
          flag_mismatch($sformatf("occupied_count got %0d want %0d",
                                  occupied_count, want.count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("[%0t] timeout, %0d results outstanding", $time, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n_reqs;
    int round;
    int len;
    int k;
    int j;
    int roll;
    int pick;
    mix_e mix;
    logic [ROW_W-1:0] base_row;
    logic [COL_W-1:0] base_col;
    logic [ROW_W+COL_W-1:0] sweep [128];
    logic [ROW_W+COL_W-1:0] swap;

    // Directed: empty table, ordering at the extremes, update, delete at each end
    add_read(7'd0);
    add_write(16'h0000, 16'h0000, 32'sd0);
    add_write(16'h1234, 16'h5678, 32'sh7FFF_FFFF);
    add_write(16'h0000, 16'h0000, 32'sh8000_0000);
    add_write(16'hFFFF, 16'hFFFF, -32'sd1);
    add_write(16'h1234, 16'h0001, 32'sd5);
    add_write(16'h1234, 16'h5678, 32'sd42);
    add_read(7'd0);
    add_read(7'd1);
    add_read(7'd2);
    add_read(7'd3);
    add_read(7'd4);
    add_read(7'd127);
    add_write(16'h1234, 16'h0001, 32'sd0);
    add_write(16'h0000, 16'h0000, 32'sd0);
    add_read(7'd0);
    add_write(16'hFFFF, 16'hFFFF, 32'sd0);
    // row outranks column in the key
    add_write(16'h0101, 16'h0000, 32'sd2);
    add_write(16'h0100, 16'hFFFF, 32'sd1);
    add_read(7'd0);
    add_read(7'd1);
    add_read(7'd2);

    // Random rounds, mostly over a small key window so the table fills, overflows and drains
    n_reqs = 0;
    round = 0;
    base_row = '0;
    base_col = '0;
    while (n_reqs < RAND_REQS) begin
      mix = mix_e'(round % 4);
      if (mix == MIX_FILL) begin
        base_row = ROW_W'($urandom);
        base_col = COL_W'($urandom);
      end
      round++;
      if (mix == MIX_DRAIN) begin
        for (k = 0; k < 128; k++)
          sweep[k] = {base_row + ROW_W'(k / 16), base_col + COL_W'(k % 16)};
        for (k = 127; k > 0; k--) begin
          j = $urandom_range(0, k);
          swap = sweep[k];
          sweep[k] = sweep[j];
          sweep[j] = swap;
        end
        for (k = 0; k < 128; k++) begin
          add_write(sweep[k][ROW_W+COL_W-1:COL_W], sweep[k][COL_W-1:0], 32'sd0);
          if ($urandom_range(0, 5) == 0) begin
            add_read(pick_index());
            n_reqs++;
          end
        end
        n_reqs += 128;
      end else begin
        len = (mix == MIX_WIDE) ? $urandom_range(40, 60) : $urandom_range(80, 110);
        for (k = 0; k < len; k++) begin
          roll = $urandom_range(0, 99);
          pick = $urandom_range(0, 127);
          case (mix)
            MIX_FILL: begin
              if (roll < 90) add_write(base_row + ROW_W'(pick / 16), base_col + COL_W'(pick % 16),
                                       nonzero_value());
              else add_read(pick_index());
            end
            MIX_CHURN: begin
              if (roll < 40) add_write(base_row + ROW_W'(pick / 16),
                                       base_col + COL_W'(pick % 16), nonzero_value());
              else if (roll < 70) add_write(base_row + ROW_W'(pick / 16),
                                            base_col + COL_W'(pick % 16), 32'sd0);
              else add_read(pick_index());
            end
            default: begin
              if (roll < 50) add_write(ROW_W'($urandom), COL_W'($urandom),
                                       (roll < 15) ? 32'sd0 : nonzero_value());
              else add_read(IDX_W'($urandom_range(0, 127)));
            end
          endcase
        end
        n_reqs += len;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
